// ===== hdl/kwbpm_pkg.sv =====
// ============================================================================
// K-weighted block power meter package
// Shared widths, register indexes, reset values and types.
// ============================================================================
package kwbpm_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 32;
    localparam int COEF_FRAC    = 28;
    localparam int SAMPLE_SHIFT = COEF_FRAC - SAMPLE_W + 1;
    localparam int PROD_W       = 2 * COEF_W;
    localparam int TERM_W       = PROD_W - COEF_FRAC;
    localparam int ACC_W        = 40;

    localparam int HOPS          = 4;
    localparam int HOP_SHIFT     = $clog2(HOPS);
    localparam int MAX_BLOCK_LEN = 65536;
    localparam int HOP_MAX       = MAX_BLOCK_LEN / HOPS;
    localparam int HOP_W         = $clog2(HOP_MAX) + 1;
    localparam int POS_W         = $clog2(HOP_MAX);
    localparam int FILL_W        = $clog2(HOPS) + 1;
    localparam int RING_W        = 48;
    localparam int TOTAL_W       = RING_W + HOP_SHIFT;
    localparam int DIV_W         = RING_W;
    localparam int DIV_CNT_W     = $clog2(DIV_W);
    localparam int POWER_W       = 32;
    localparam int BLEN_W        = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SHELF_B0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELF_B1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELF_B2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELF_A1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELF_A2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS_A1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS_A2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN   = 3'd7;

    localparam logic signed [COEF_W-1:0] RST_SHELF_B0    = 32'sd412081942;
    localparam logic signed [COEF_W-1:0] RST_SHELF_B1    = -32'sd722546694;
    localparam logic signed [COEF_W-1:0] RST_SHELF_B2    = 32'sd321691119;
    localparam logic signed [COEF_W-1:0] RST_SHELF_A1    = -32'sd453832899;
    localparam logic signed [COEF_W-1:0] RST_SHELF_A2    = 32'sd196623811;
    localparam logic signed [COEF_W-1:0] RST_HIGHPASS_A1 = -32'sd534199295;
    localparam logic signed [COEF_W-1:0] RST_HIGHPASS_A2 = 32'sd265770496;
    localparam logic [BLEN_W-1:0]        RST_BLOCK_LEN   = 17'd19200;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [RING_W-1:0]          t_ring;
    typedef logic [HOP_W-1:0]           t_hop;

endpackage

// ===== hdl/kwbpm_in_if.sv =====
// ============================================================================
// Sample channel
// Carries one audio sample per transaction with a valid/ready handshake.
// ============================================================================
interface kwbpm_in_if;
    logic              valid;
    logic              ready;
    kwbpm_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// ===== hdl/kwbpm_out_if.sv =====
// ============================================================================
// Result channel
// Carries one block power result per transaction with a valid/ready handshake.
// ============================================================================
interface kwbpm_out_if;
    logic                             valid;
    logic                             ready;
    logic                             block_valid;
    logic [kwbpm_pkg::POWER_W-1:0]    block_power;
    logic [kwbpm_pkg::SAMPLE_W-1:0]   peak;

    modport source (output valid, output block_valid, output block_power, output peak,
                    input ready);
    modport sink (input valid, input block_valid, input block_power, input peak,
                  output ready);
endinterface

// ===== hdl/k_weighted_block_power_meter.sv =====
// ============================================================================
// K-weighted block power meter
// Two cascaded biquads on a shared multiplier, hop sums and window mean.
// ============================================================================
// Each accepted sample runs the filter steps, FIN1, FIN2, SQ and SQACC; a hop end
// adds SUM, and a hop that completes a window also waits on the divider.
// A new sample is accepted in the cycle after each result loads, so one sample
// is finished before the next is taken; the divider sets the worst case.
// Seven filter products and one square share a single 32x32 multiplier.
// Synchronous active-low reset clears all history and loads 48 kHz taps.
// ============================================================================
module k_weighted_block_power_meter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kwbpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kwbpm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    kwbpm_in_if.sink                           i_smp,
    kwbpm_out_if.source                        o_res
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILT  = 4'd1;
    localparam logic [3:0] ST_FIN1  = 4'd2;
    localparam logic [3:0] ST_FIN2  = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_SQACC = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;
    localparam logic [3:0] ST_DIVW  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam logic [2:0] LAST_STEP = 3'd7;

    kwbpm_pkg::t_coef r_sb0, r_sb1, r_sb2, r_sa1, r_sa2, r_ha1, r_ha2;
    logic [kwbpm_pkg::BLEN_W-1:0] r_block_len;

    logic [3:0]              r_state;
    logic [2:0]              r_step;
    kwbpm_pkg::t_sample      r_x;
    kwbpm_pkg::t_sample      r_si0, r_si1;
    kwbpm_pkg::t_coef        r_so0, r_so1, r_hi0, r_hi1, r_ho0, r_ho1;
    kwbpm_pkg::t_acc         r_acc1, r_acc2;
    logic signed [kwbpm_pkg::PROD_W-1:0] r_prod;
    kwbpm_pkg::t_ring        r_ring [kwbpm_pkg::HOPS];
    logic [kwbpm_pkg::POS_W-1:0]  r_hop_pos;
    logic [kwbpm_pkg::FILL_W-1:0] r_filled;
    logic [kwbpm_pkg::SAMPLE_W-1:0] r_peak;
    logic                    r_emit;
    logic                    r_out_vld;
    logic                    r_out_bv;
    logic [kwbpm_pkg::POWER_W-1:0] r_out_pow;
    logic [kwbpm_pkg::SAMPLE_W-1:0] r_out_peak;

    logic                    in_acc;
    logic [kwbpm_pkg::SAMPLE_W:0] neg_x;
    logic [kwbpm_pkg::SAMPLE_W-1:0] mag;
    kwbpm_pkg::t_coef        mul_a, mul_b;
    logic signed [kwbpm_pkg::PROD_W-1:0] prod_full;
    logic signed [kwbpm_pkg::TERM_W-1:0] term;
    kwbpm_pkg::t_acc         term_ext;
    logic [2:0]              prod_idx;
    kwbpm_pkg::t_coef        y1, y2;
    kwbpm_pkg::t_acc         n_acc2;
    logic [kwbpm_pkg::TERM_W-1:0] sq;
    logic [kwbpm_pkg::RING_W:0]   ring_sum;
    kwbpm_pkg::t_ring        n_ring0;
    logic [kwbpm_pkg::HOP_W-1:0]  hop_div4;
    kwbpm_pkg::t_hop         hop;
    logic                    hop_end;
    logic [kwbpm_pkg::TOTAL_W-1:0] total;
    logic                    div_start;
    logic                    div_done;
    logic [kwbpm_pkg::DIV_W-1:0] quotient;
    logic [kwbpm_pkg::POWER_W-1:0] power_sat;
    logic                    out_load;

    function automatic kwbpm_pkg::t_coef sat32(input kwbpm_pkg::t_acc v);
        kwbpm_pkg::t_coef r;
        if (v > kwbpm_pkg::t_acc'({1'b0, {(kwbpm_pkg::COEF_W-1){1'b1}}})) begin
            r = {1'b0, {(kwbpm_pkg::COEF_W-1){1'b1}}};
        end else if (v < -kwbpm_pkg::t_acc'({1'b1, {(kwbpm_pkg::COEF_W-1){1'b0}}})) begin
            r = {1'b1, {(kwbpm_pkg::COEF_W-1){1'b0}}};
        end else begin
            r = v[kwbpm_pkg::COEF_W-1:0];
        end
        return r;
    endfunction

    function automatic kwbpm_pkg::t_coef to_q28(input kwbpm_pkg::t_sample s);
        return {{(kwbpm_pkg::COEF_W - kwbpm_pkg::SAMPLE_W - kwbpm_pkg::SAMPLE_SHIFT)
                 {s[kwbpm_pkg::SAMPLE_W-1]}}, s, {kwbpm_pkg::SAMPLE_SHIFT{1'b0}}};
    endfunction

    assign in_acc      = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == ST_IDLE);

    assign neg_x = -{i_smp.sample[kwbpm_pkg::SAMPLE_W-1], i_smp.sample};
    assign mag   = i_smp.sample[kwbpm_pkg::SAMPLE_W-1] ? neg_x[kwbpm_pkg::SAMPLE_W-1:0]
                                                      : i_smp.sample;

    always_comb begin
        if (r_state == ST_SQ) begin
            mul_a = r_ho0;
            mul_b = r_ho0;
        end else begin
            unique case (r_step)
                3'd0: begin mul_a = r_sb0; mul_b = to_q28(r_x);   end
                3'd1: begin mul_a = r_sb1; mul_b = to_q28(r_si0); end
                3'd2: begin mul_a = r_sb2; mul_b = to_q28(r_si1); end
                3'd3: begin mul_a = r_sa1; mul_b = r_so0;         end
                3'd4: begin mul_a = r_sa2; mul_b = r_so1;         end
                3'd5: begin mul_a = r_ha1; mul_b = r_ho0;         end
                3'd6: begin mul_a = r_ha2; mul_b = r_ho1;         end
                default: begin mul_a = '0; mul_b = '0;            end
            endcase
        end
    end

    assign prod_full = mul_a * mul_b;
    assign term      = r_prod[kwbpm_pkg::PROD_W-1:kwbpm_pkg::COEF_FRAC];
    assign term_ext  = kwbpm_pkg::t_acc'(term);
    assign prod_idx  = r_step - 3'd1;

    assign y1     = sat32(r_acc1);
    assign n_acc2 = r_acc2 + kwbpm_pkg::t_acc'(y1) - (kwbpm_pkg::t_acc'(r_hi0) <<< 1)
                    + kwbpm_pkg::t_acc'(r_hi1);
    assign y2     = sat32(r_acc2);

    assign sq       = r_prod[kwbpm_pkg::PROD_W-1:kwbpm_pkg::COEF_FRAC];
    assign ring_sum = {1'b0, r_ring[0]} + (kwbpm_pkg::RING_W + 1)'(sq);
    assign n_ring0  = ring_sum[kwbpm_pkg::RING_W] ? {kwbpm_pkg::RING_W{1'b1}}
                                                  : ring_sum[kwbpm_pkg::RING_W-1:0];

    assign hop_div4 = kwbpm_pkg::HOP_W'(r_block_len >> kwbpm_pkg::HOP_SHIFT);
    always_comb begin
        priority if (hop_div4 == '0) begin
            hop = kwbpm_pkg::HOP_W'(1);
        end else if (hop_div4 > kwbpm_pkg::HOP_W'(kwbpm_pkg::HOP_MAX)) begin
            hop = kwbpm_pkg::HOP_W'(kwbpm_pkg::HOP_MAX);
        end else begin
            hop = hop_div4;
        end
    end
    assign hop_end = ({1'b0, r_hop_pos} + kwbpm_pkg::HOP_W'(1)) >= hop;

    always_comb begin
        total = '0;
        for (int i = 0; i < kwbpm_pkg::HOPS; i++) begin
            total = total + kwbpm_pkg::TOTAL_W'(r_ring[i]);
        end
    end

    assign div_start = (r_state == ST_SUM) && r_emit;

    kwbpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (total[kwbpm_pkg::TOTAL_W-1:kwbpm_pkg::HOP_SHIFT]),
        .i_divisor  (hop),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign power_sat = (quotient[kwbpm_pkg::DIV_W-1:kwbpm_pkg::POWER_W] != '0)
                       ? {kwbpm_pkg::POWER_W{1'b1}} : quotient[kwbpm_pkg::POWER_W-1:0];
    assign out_load  = (r_state == ST_DONE) && (!r_out_vld || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb0       <= kwbpm_pkg::RST_SHELF_B0;
            r_sb1       <= kwbpm_pkg::RST_SHELF_B1;
            r_sb2       <= kwbpm_pkg::RST_SHELF_B2;
            r_sa1       <= kwbpm_pkg::RST_SHELF_A1;
            r_sa2       <= kwbpm_pkg::RST_SHELF_A2;
            r_ha1       <= kwbpm_pkg::RST_HIGHPASS_A1;
            r_ha2       <= kwbpm_pkg::RST_HIGHPASS_A2;
            r_block_len <= kwbpm_pkg::RST_BLOCK_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kwbpm_pkg::CFG_SHELF_B0:    r_sb0 <= i_cfg_data;
                kwbpm_pkg::CFG_SHELF_B1:    r_sb1 <= i_cfg_data;
                kwbpm_pkg::CFG_SHELF_B2:    r_sb2 <= i_cfg_data;
                kwbpm_pkg::CFG_SHELF_A1:    r_sa1 <= i_cfg_data;
                kwbpm_pkg::CFG_SHELF_A2:    r_sa2 <= i_cfg_data;
                kwbpm_pkg::CFG_HIGHPASS_A1: r_ha1 <= i_cfg_data;
                kwbpm_pkg::CFG_HIGHPASS_A2: r_ha2 <= i_cfg_data;
                kwbpm_pkg::CFG_BLOCK_LEN:   r_block_len <= i_cfg_data[kwbpm_pkg::BLEN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_si0     <= '0;
            r_si1     <= '0;
            r_so0     <= '0;
            r_so1     <= '0;
            r_hi0     <= '0;
            r_hi1     <= '0;
            r_ho0     <= '0;
            r_ho1     <= '0;
            r_hop_pos <= '0;
            r_filled  <= '0;
            r_peak    <= '0;
            r_emit    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < kwbpm_pkg::HOPS; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_vld  <= 1'b1;
                r_out_bv   <= r_emit;
                r_out_pow  <= r_emit ? power_sat : '0;
                r_out_peak <= r_peak;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_x     <= i_smp.sample;
                        r_acc1  <= '0;
                        r_acc2  <= '0;
                        r_step  <= '0;
                        r_emit  <= 1'b0;
                        if (mag > r_peak) begin
                            r_peak <= mag;
                        end
                        r_state <= ST_FILT;
                    end
                end
                ST_FILT: begin
                    if (r_step != '0) begin
                        priority if (prod_idx < 3'd3) begin
                            r_acc1 <= r_acc1 + term_ext;
                        end else if (prod_idx < 3'd5) begin
                            r_acc1 <= r_acc1 - term_ext;
                        end else begin
                            r_acc2 <= r_acc2 - term_ext;
                        end
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_FIN1;
                    end
                end
                ST_FIN1: begin
                    r_acc2  <= n_acc2;
                    r_si1   <= r_si0;
                    r_si0   <= r_x;
                    r_so1   <= r_so0;
                    r_so0   <= y1;
                    r_hi1   <= r_hi0;
                    r_hi0   <= y1;
                    r_state <= ST_FIN2;
                end
                ST_FIN2: begin
                    r_ho1   <= r_ho0;
                    r_ho0   <= y2;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_state <= ST_SQACC;
                end
                ST_SQACC: begin
                    r_ring[0] <= n_ring0;
                    if (hop_end) begin
                        r_hop_pos <= '0;
                        if (r_filled < kwbpm_pkg::FILL_W'(kwbpm_pkg::HOPS)) begin
                            r_filled <= r_filled + 1'b1;
                        end
                        r_emit  <= r_filled >= kwbpm_pkg::FILL_W'(kwbpm_pkg::HOPS - 1);
                        r_state <= ST_SUM;
                    end else begin
                        r_hop_pos <= r_hop_pos + 1'b1;
                        r_state   <= ST_DONE;
                    end
                end
                ST_SUM: begin
                    for (int i = kwbpm_pkg::HOPS - 1; i > 0; i--) begin
                        r_ring[i] <= r_ring[i-1];
                    end
                    r_ring[0] <= '0;
                    r_state   <= r_emit ? ST_DIVW : ST_DONE;
                end
                ST_DIVW: begin
                    if (div_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.block_valid = r_out_bv;
    assign o_res.block_power = r_out_pow;
    assign o_res.peak        = r_out_peak;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIVW))
        else $error("Divider finished outside its wait state.");

    a_accept_starts_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_FILT) && (r_step == '0))
        else $error("Accepted sample did not start the filter sequence.");

    a_no_power_without_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_bv) |-> (r_out_pow == '0))
        else $error("Nonzero power reported without a full window.");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= kwbpm_pkg::FILL_W'(kwbpm_pkg::HOPS))
        else $error("Completed hop count exceeds the ring depth.");

    a_emit_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_filled == kwbpm_pkg::FILL_W'(kwbpm_pkg::HOPS)))
        else $error("Window mean started before the ring was full.");

endmodule

// ===== hdl/kwbpm_div.sv =====
// ============================================================================
// Window mean divider
// Restoring divider that produces one quotient bit per cycle while busy.
// ============================================================================
module kwbpm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [kwbpm_pkg::DIV_W-1:0]    i_dividend,
    input  logic [kwbpm_pkg::HOP_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [kwbpm_pkg::DIV_W-1:0]    o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [kwbpm_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [kwbpm_pkg::DIV_W-1:0]       r_quo;
    logic [kwbpm_pkg::HOP_W-1:0]       r_rem;
    logic [kwbpm_pkg::HOP_W-1:0]       r_dvs;

    logic [kwbpm_pkg::HOP_W:0]         shifted;
    logic [kwbpm_pkg::HOP_W:0]         diff;
    logic                              ge;

    assign shifted = {r_rem, r_quo[kwbpm_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[kwbpm_pkg::DIV_W-2:0], ge};
                r_rem <= ge ? diff[kwbpm_pkg::HOP_W-1:0] : shifted[kwbpm_pkg::HOP_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == kwbpm_pkg::DIV_CNT_W'(kwbpm_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== tb/kwbpm_power_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Block power meter checker
// Follows the configuration port and both channels, runs its own copy of the
// filter cascade and hop accumulation for every accepted sample, and compares
// each result transaction field by field with the oldest prediction.
// ============================================================================
module kwbpm_power_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kwbpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kwbpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    kwbpm_in_if                              i_smp,
    kwbpm_out_if                             i_res,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam longint HOP_SUM_MAX = (longint'(1) << kwbpm_pkg::RING_W) - 1;
    localparam longint POWER_MAX   = (longint'(1) << kwbpm_pkg::POWER_W) - 1;
    localparam longint COEF_HI     = (longint'(1) << (kwbpm_pkg::COEF_W - 1)) - 1;
    localparam longint COEF_LO     = -(longint'(1) << (kwbpm_pkg::COEF_W - 1));

    typedef struct packed {
        logic                           block_valid;
        logic [kwbpm_pkg::POWER_W-1:0]  block_power;
        logic [kwbpm_pkg::SAMPLE_W-1:0] peak;
    } t_meter_result;

    kwbpm_pkg::t_coef               shelf_b0, shelf_b1, shelf_b2, shelf_a1, shelf_a2;
    kwbpm_pkg::t_coef               hp_a1, hp_a2;
    logic [kwbpm_pkg::BLEN_W-1:0]   block_len;
    kwbpm_pkg::t_sample             shelf_x_hist [2];
    kwbpm_pkg::t_coef               shelf_y_hist [2];
    kwbpm_pkg::t_coef               hp_x_hist [2];
    kwbpm_pkg::t_coef               hp_y_hist [2];
    kwbpm_pkg::t_ring               hop_ring [kwbpm_pkg::HOPS];
    logic [kwbpm_pkg::POS_W-1:0]    hop_pos;
    logic [kwbpm_pkg::FILL_W-1:0]   hops_done;
    logic [kwbpm_pkg::SAMPLE_W-1:0] peak_hold;
    t_meter_result                  expected_results [$];
    t_meter_result                  got_result, want_result;
    int                             fail_count = 0;

    function automatic longint tap(kwbpm_pkg::t_coef c, longint v);
        return (longint'(c) * v) >>> kwbpm_pkg::COEF_FRAC;
    endfunction

    function automatic kwbpm_pkg::t_coef clip32(longint v);
        if (v > COEF_HI) begin
            return kwbpm_pkg::t_coef'(COEF_HI);
        end
        if (v < COEF_LO) begin
            return kwbpm_pkg::t_coef'(COEF_LO);
        end
        return kwbpm_pkg::t_coef'(v);
    endfunction

    // Advances the filter and hop state by one sample and returns its result.
    function automatic t_meter_result meter_sample(kwbpm_pkg::t_sample x);
        longint        xs, mag, acc, y1, y2, sq, ring_sum, total, hop_len;
        t_meter_result r;
        xs  = longint'(x);
        mag = (xs < 0) ? -xs : xs;
        if (mag > longint'(peak_hold)) begin
            peak_hold = mag[kwbpm_pkg::SAMPLE_W-1:0];
        end

        acc = tap(shelf_b0, xs <<< kwbpm_pkg::SAMPLE_SHIFT)
            + tap(shelf_b1, longint'(shelf_x_hist[0]) <<< kwbpm_pkg::SAMPLE_SHIFT)
            + tap(shelf_b2, longint'(shelf_x_hist[1]) <<< kwbpm_pkg::SAMPLE_SHIFT)
            - tap(shelf_a1, longint'(shelf_y_hist[0]))
            - tap(shelf_a2, longint'(shelf_y_hist[1]));
        y1 = longint'(clip32(acc));
        shelf_x_hist[1] = shelf_x_hist[0];
        shelf_x_hist[0] = x;
        shelf_y_hist[1] = shelf_y_hist[0];
        shelf_y_hist[0] = kwbpm_pkg::t_coef'(y1);

        acc = y1 - 2 * longint'(hp_x_hist[0]) + longint'(hp_x_hist[1])
            - tap(hp_a1, longint'(hp_y_hist[0]))
            - tap(hp_a2, longint'(hp_y_hist[1]));
        y2 = longint'(clip32(acc));
        hp_x_hist[1] = hp_x_hist[0];
        hp_x_hist[0] = kwbpm_pkg::t_coef'(y1);
        hp_y_hist[1] = hp_y_hist[0];
        hp_y_hist[0] = kwbpm_pkg::t_coef'(y2);

        sq       = (y2 * y2) >> kwbpm_pkg::COEF_FRAC;
        ring_sum = longint'(hop_ring[0]) + sq;
        if (ring_sum > HOP_SUM_MAX) begin
            ring_sum = HOP_SUM_MAX;
        end
        hop_ring[0] = ring_sum[kwbpm_pkg::RING_W-1:0];

        hop_len = longint'(block_len >> kwbpm_pkg::HOP_SHIFT);
        if (hop_len < 1) begin
            hop_len = 1;
        end
        if (hop_len > kwbpm_pkg::HOP_MAX) begin
            hop_len = kwbpm_pkg::HOP_MAX;
        end

        r      = '0;
        r.peak = peak_hold;
        if (longint'(hop_pos) + 1 >= hop_len) begin
            hop_pos = '0;
            if (hops_done < kwbpm_pkg::HOPS) begin
                hops_done = hops_done + 1'b1;
            end
            if (hops_done >= kwbpm_pkg::HOPS) begin
                total = 0;
                for (int i = 0; i < kwbpm_pkg::HOPS; i++) begin
                    total += longint'(hop_ring[i]);
                end
                total = total / (hop_len * kwbpm_pkg::HOPS);
                if (total > POWER_MAX) begin
                    total = POWER_MAX;
                end
                r.block_valid = 1'b1;
                r.block_power = total[kwbpm_pkg::POWER_W-1:0];
            end
            for (int i = kwbpm_pkg::HOPS - 1; i > 0; i--) begin
                hop_ring[i] = hop_ring[i-1];
            end
            hop_ring[0] = '0;
        end else begin
            hop_pos = hop_pos + 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shelf_b0  = kwbpm_pkg::RST_SHELF_B0;
            shelf_b1  = kwbpm_pkg::RST_SHELF_B1;
            shelf_b2  = kwbpm_pkg::RST_SHELF_B2;
            shelf_a1  = kwbpm_pkg::RST_SHELF_A1;
            shelf_a2  = kwbpm_pkg::RST_SHELF_A2;
            hp_a1     = kwbpm_pkg::RST_HIGHPASS_A1;
            hp_a2     = kwbpm_pkg::RST_HIGHPASS_A2;
            block_len = kwbpm_pkg::RST_BLOCK_LEN;
            for (int i = 0; i < 2; i++) begin
                shelf_x_hist[i] = '0;
                shelf_y_hist[i] = '0;
                hp_x_hist[i]    = '0;
                hp_y_hist[i]    = '0;
            end
            for (int i = 0; i < kwbpm_pkg::HOPS; i++) begin
                hop_ring[i] = '0;
            end
            hop_pos   = '0;
            hops_done = '0;
            peak_hold = '0;
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got_result = {i_res.block_valid, i_res.block_power, i_res.peak};
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with none expected, got %h",
                             $time, got_result);
                    fail_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    check_field("block_valid", want_result.block_valid, got_result.block_valid);
                    check_field("block_power", want_result.block_power, got_result.block_power);
                    check_field("peak", want_result.peak, got_result.peak);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kwbpm_pkg::CFG_SHELF_B0:    shelf_b0  = i_cfg_data;
                    kwbpm_pkg::CFG_SHELF_B1:    shelf_b1  = i_cfg_data;
                    kwbpm_pkg::CFG_SHELF_B2:    shelf_b2  = i_cfg_data;
                    kwbpm_pkg::CFG_SHELF_A1:    shelf_a1  = i_cfg_data;
                    kwbpm_pkg::CFG_SHELF_A2:    shelf_a2  = i_cfg_data;
                    kwbpm_pkg::CFG_HIGHPASS_A1: hp_a1     = i_cfg_data;
                    kwbpm_pkg::CFG_HIGHPASS_A2: hp_a2     = i_cfg_data;
                    kwbpm_pkg::CFG_BLOCK_LEN:   block_len = i_cfg_data[kwbpm_pkg::BLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_smp.valid && i_smp.ready) begin
                expected_results.insert(expected_results.size(),
                                        meter_sample(i_smp.sample));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

// ===== tb/tb_k_weighted_block_power_meter.sv =====
`timescale 1ns / 100ps
// ============================================================================
// K-weighted block power meter testbench
// Drives samples and tap settings into the meter with random idle bursts on
// both channels; a checker beside the block predicts and compares results.
// ============================================================================
module tb_k_weighted_block_power_meter;

    localparam kwbpm_pkg::t_sample SAMPLE_MAX = 24'sh7FFFFF;
    localparam kwbpm_pkg::t_sample SAMPLE_MIN = 24'sh800000;
    localparam kwbpm_pkg::t_coef   COEF_MAX   = 32'sh7FFFFFFF;
    localparam kwbpm_pkg::t_coef   COEF_MIN   = 32'sh80000000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [kwbpm_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [kwbpm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                             idle_en;
    int                               ready_hold = 0;
    int                               fail_count;
    int                               pending;
    kwbpm_pkg::t_coef                 default_taps [7];
    kwbpm_pkg::t_coef                 filter_taps [7];
    kwbpm_pkg::t_sample               edge_samples [7];

    kwbpm_in_if  smp ();
    kwbpm_out_if res ();

    k_weighted_block_power_meter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp),
        .o_res      (res)
    );

    kwbpm_power_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_smp        (smp),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            res.ready  <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 5);
            res.ready  <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    task automatic send_sample(kwbpm_pkg::t_sample s);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        smp.valid  <= 1'b1;
        smp.sample <= s;
        do @(posedge i_clk); while (!smp.ready);
    endtask

    task automatic wait_idle();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [kwbpm_pkg::CFG_IDX_W-1:0] idx,
                             logic [kwbpm_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Waits until the meter is idle, then loads filter_taps and the block length.
    task automatic load_filter(logic [kwbpm_pkg::BLEN_W-1:0] blen);
        wait_idle();
        write_reg(kwbpm_pkg::CFG_SHELF_B0, filter_taps[0]);
        write_reg(kwbpm_pkg::CFG_SHELF_B1, filter_taps[1]);
        write_reg(kwbpm_pkg::CFG_SHELF_B2, filter_taps[2]);
        write_reg(kwbpm_pkg::CFG_SHELF_A1, filter_taps[3]);
        write_reg(kwbpm_pkg::CFG_SHELF_A2, filter_taps[4]);
        write_reg(kwbpm_pkg::CFG_HIGHPASS_A1, filter_taps[5]);
        write_reg(kwbpm_pkg::CFG_HIGHPASS_A2, filter_taps[6]);
        write_reg(kwbpm_pkg::CFG_BLOCK_LEN, kwbpm_pkg::CFG_DATA_W'(blen));
        cfg_we <= 1'b0;
    endtask

    function automatic kwbpm_pkg::t_sample pick_sample();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2:    return kwbpm_pkg::t_sample'(int'($urandom_range(0, 511)) - 256);
            3:       return kwbpm_pkg::t_sample'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
            default: return kwbpm_pkg::t_sample'($urandom);
        endcase
    endfunction

    initial begin
        int                           tap_mode;
        logic [kwbpm_pkg::BLEN_W-1:0] blen;

        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        smp.valid  = 1'b0;
        smp.sample = '0;
        idle_en    = 1'b0;
        default_taps = '{kwbpm_pkg::RST_SHELF_B0, kwbpm_pkg::RST_SHELF_B1,
                         kwbpm_pkg::RST_SHELF_B2, kwbpm_pkg::RST_SHELF_A1,
                         kwbpm_pkg::RST_SHELF_A2, kwbpm_pkg::RST_HIGHPASS_A1,
                         kwbpm_pkg::RST_HIGHPASS_A2};
        edge_samples = '{24'sd0, SAMPLE_MAX, SAMPLE_MIN, -24'sd1, 24'sd1,
                         24'sh555555, 24'shAAAAAA};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Four short hops from reset give the first full window on the last sample.
        filter_taps = default_taps;
        load_filter(17'd16);
        foreach (edge_samples[i]) begin
            send_sample(edge_samples[i]);
        end
        repeat (9) send_sample(pick_sample());

        // An oversized length is clamped; the odd one that follows ends the hop at once.
        load_filter(17'h1FFFF);
        repeat (5) send_sample(pick_sample());
        load_filter(17'd7);
        repeat (4) send_sample(pick_sample());

        for (int p = 0; p < 13; p++) begin
            tap_mode = (p < 3) ? 3 + p : $urandom_range(0, 5);
            foreach (filter_taps[i]) begin
                case (tap_mode)
                    3:       filter_taps[i] = COEF_MIN;
                    4:       filter_taps[i] = COEF_MAX;
                    5:       filter_taps[i] = '0;
                    6:       filter_taps[i] = default_taps[i]
                                 + kwbpm_pkg::t_coef'(int'($urandom_range(0, 1 << 20))
                                                      - (1 << 19));
                    7:       filter_taps[i] = kwbpm_pkg::t_coef'($urandom);
                    default: filter_taps[i] = default_taps[i];
                endcase
            end
            if (tap_mode >= 3 && p >= 3) begin
                tap_mode = 6 + $urandom_range(0, 2);
                foreach (filter_taps[i]) begin
                    case (tap_mode)
                        6:       filter_taps[i] = default_taps[i]
                                     + kwbpm_pkg::t_coef'(int'($urandom_range(0, 1 << 20))
                                                          - (1 << 19));
                        7:       filter_taps[i] = kwbpm_pkg::t_coef'($urandom);
                        default: filter_taps[i] = $urandom_range(0, 1) ? COEF_MIN : COEF_MAX;
                    endcase
                end
            end
            case (p)
                0:       blen = '0;
                1:       blen = 17'h1FFFF;
                2:       blen = 17'd4;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       blen = kwbpm_pkg::BLEN_W'($urandom_range(0, 127));
                        3:       blen = kwbpm_pkg::BLEN_W'(4 * $urandom_range(17, 64));
                        default: blen = kwbpm_pkg::BLEN_W'(4 * $urandom_range(1, 16));
                    endcase
                end
            endcase
            load_filter(blen);
            idle_en = ($urandom_range(0, 3) != 0);
            repeat (100) send_sample(pick_sample());
        end

        // Full-scale taps and runaway high-pass feedback hold both biquads in saturation.
        foreach (filter_taps[i]) begin
            filter_taps[i] = '0;
        end
        filter_taps[0] = COEF_MAX;
        load_filter('0);
        repeat (3) send_sample(SAMPLE_MAX);
        filter_taps[5] = COEF_MIN;
        load_filter(17'd64);
        send_sample(SAMPLE_MIN);
        repeat (15) send_sample(kwbpm_pkg::t_sample'($urandom));

        filter_taps = default_taps;
        load_filter(17'd8);
        idle_en = 1'b0;
        repeat (100) send_sample(pick_sample());

        wait_idle();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_k_weighted_block_power_meter passed");
        end else begin
            $display("tb_k_weighted_block_power_meter failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_k_weighted_block_power_meter failed");
        $finish;
    end

endmodule
